// ===== sv/isbr_pkg.sv =====
// Package for the inverted serial burst receiver: field widths, register
// indexes, reset values and the result type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isbr_pkg;

   localparam int unsigned TickW    = 10;  // bit_ticks and tick counter
   localparam int unsigned ByteW    = 8;   // data byte, msg_bytes, byte counter
   localparam int unsigned SlotW    = 4;   // bit slot within a byte frame
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 10;

   localparam logic [SlotW-1:0] DataSlots = 4'd8;  // last data slot of a byte

   localparam logic [TickW-1:0] BitTicksReset = 10'd10;
   localparam logic [ByteW-1:0] MsgBytesReset = 8'd10;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BIT_TICKS = 2'd0,
      CSR_MSG_BYTES = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data_byte;
      logic             last_of_message;
   } result_type;

endpackage : isbr_pkg

`default_nettype wire

// ===== sv/isbr_if.sv =====
// Channel interfaces of the receiver: line samples in, bytes out, and the
// register write port. Depends on isbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface isbr_req_if;
   logic valid;
   logic ready;
   logic line_level;

   modport source (output valid, output line_level, input ready);
   modport sink   (input valid, input line_level, output ready);
endinterface : isbr_req_if

interface isbr_rsp_if import isbr_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             last_of_message;

   modport source (output valid, output data_byte, output last_of_message, input ready);
   modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface : isbr_rsp_if

interface isbr_csr_if import isbr_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : isbr_csr_if

`default_nettype wire

// ===== sv/isbr_frame.sv =====
// Frame tracker: bit period counter, bit slot, byte counter and shift
// register, advanced at most once per line sample. Depends on isbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isbr_frame
   import isbr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             line_level,
   input  wire logic [TickW-1:0] bit_ticks,
   input  wire logic [ByteW-1:0] msg_bytes,
   output      result_type       result
);

   logic             receiving_ff, receiving_in;
   logic [TickW-1:0] tick_count_ff, tick_count_in;
   logic [SlotW-1:0] bit_slot_ff, bit_slot_in;
   logic [ByteW-1:0] byte_count_ff, byte_count_in;
   logic [ByteW-1:0] shift_bits_ff, shift_bits_in;

   logic             active;
   logic [TickW-1:0] tick_cur, tick_next;
   logic [SlotW-1:0] slot_cur;
   logic [ByteW-1:0] count_cur, count_next;
   logic [ByteW-1:0] shift_cur, shift_next;
   logic             sample, emit, period_end, msg_done;

   always_comb begin
      // a low line while idle opens a start period on this very sample
      active    = receiving_ff || !line_level;
      tick_cur  = receiving_ff ? tick_count_ff : '0;
      slot_cur  = receiving_ff ? bit_slot_ff   : '0;
      count_cur = receiving_ff ? byte_count_ff : '0;
      shift_cur = receiving_ff ? shift_bits_ff : '0;

      sample     = (tick_cur == '0) && (slot_cur != '0) && (slot_cur <= DataSlots);
      emit       = sample && (slot_cur == DataSlots);
      shift_next = sample ? {shift_cur[ByteW-2:0], ~line_level} : shift_cur;
      count_next = emit ? count_cur + 1'b1 : count_cur;
      msg_done   = (count_next >= msg_bytes);

      result.valid           = step && active && emit;
      result.data_byte       = shift_next;
      result.last_of_message = msg_done;

      tick_next  = tick_cur + 1'b1;
      period_end = (tick_next >= bit_ticks);

      receiving_in  = active;
      tick_count_in = tick_next;
      bit_slot_in   = slot_cur;
      byte_count_in = count_next;
      shift_bits_in = emit ? '0 : shift_next;

      if (period_end) begin
         tick_count_in = '0;
         if (slot_cur >= DataSlots) begin
            bit_slot_in = '0;
         end else if ((slot_cur == '0) && msg_done) begin
            // skip period after the final byte: drop back to idle
            receiving_in  = 1'b0;
            byte_count_in = '0;
            shift_bits_in = '0;
         end else begin
            bit_slot_in = slot_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         tick_count_ff <= '0;
         bit_slot_ff   <= '0;
         byte_count_ff <= '0;
         shift_bits_ff <= '0;
      end else if (step && active) begin
         receiving_ff  <= receiving_in;
         tick_count_ff <= tick_count_in;
         bit_slot_ff   <= bit_slot_in;
         byte_count_ff <= byte_count_in;
         shift_bits_ff <= shift_bits_in;
      end
   end

endmodule : isbr_frame

`default_nettype wire

// ===== sv/isbr_out_reg.sv =====
// Result register: holds one finished byte until the result channel takes
// it. Depends on isbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isbr_out_reg
   import isbr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output      logic       slot_free,
   isbr_rsp_if.source      rsp
);

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] data_ff;
   logic             last_ff;

   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         data_ff <= result.data_byte;
         last_ff <= result.last_of_message;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.data_byte       = data_ff;
   assign rsp.last_of_message = last_ff;

endmodule : isbr_out_reg

`default_nettype wire

// ===== sv/inverted_serial_burst_receiver_top.sv =====
// Top level of the inverted serial burst receiver: sample register, frame
// tracker, result register and the two config registers.
// Depends on isbr_pkg, isbr_if, isbr_frame and isbr_out_reg.
//
//   channel | dir | payload                      | transfer when
//   --------+-----+------------------------------+---------------------------
//   req     | in  | line_level                   | req.valid && req.ready
//   rsp     | out | data_byte, last_of_message   | rsp.valid && rsp.ready
//   csr     | in  | index (0 bit_ticks, 1 bytes) | csr.valid && csr.ready
//
// One line sample is taken per cycle while req is ready. A sample waits in the
// sample register, then the frame tracker consumes it and a finished byte lands
// in the result register, which drives rsp.
// Reset (synchronous, active high) returns to idle with bit_ticks = 10 and
// msg_bytes = 10. req stalls only while a sample waits and the result
// register holds a byte that rsp has not taken. csr is always ready.
`timescale 1ns / 1ps
`default_nettype none

module inverted_serial_burst_receiver_top
   import isbr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   isbr_req_if.sink   req,
   isbr_rsp_if.source rsp,
   isbr_csr_if.sink   csr
);

   logic             stage_vld_ff, stage_vld_in;
   logic             line_ff;
   logic [TickW-1:0] bit_ticks_ff;
   logic [ByteW-1:0] msg_bytes_ff;
   logic             slot_free;
   logic             step;
   result_type       result;

   // advance the held sample only when the result register can take a byte
   assign step      = stage_vld_ff && slot_free;
   assign req.ready = !stage_vld_ff || step;
   assign csr.ready = 1'b1;

   always_comb begin
      if (req.valid && req.ready) begin
         stage_vld_in = 1'b1;
      end else if (step) begin
         stage_vld_in = 1'b0;
      end else begin
         stage_vld_in = stage_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   // sample payload: load on every input transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         line_ff <= req.line_level;
      end
   end

   // config registers; writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BitTicksReset;
         msg_bytes_ff <= MsgBytesReset;
      end else if (csr.valid && csr.ready) begin
         unique case (csr_index_type'(csr.index))
            CSR_BIT_TICKS: bit_ticks_ff <= csr.data[TickW-1:0];
            CSR_MSG_BYTES: msg_bytes_ff <= csr.data[ByteW-1:0];
            default: ;
         endcase
      end
   end

   isbr_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .line_level (line_ff),
      .bit_ticks  (bit_ticks_ff),
      .msg_bytes  (msg_bytes_ff),
      .result     (result)
   );

   isbr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp       (rsp)
   );

`ifndef ASSERT_OFF
   // input stalls only behind a held sample and a blocked result
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (stage_vld_ff && rsp.valid && !rsp.ready))
      else $error("req stalled without a blocked result");

   // a new byte on rsp comes from a sample consumed in the previous cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(step && result.valid))
      else $error("rsp valid rose without a finished byte");

   // a byte is never produced while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !result.valid)
      else $error("byte produced into a full result register");

   // a bit_ticks write lands in the register
   assert property (@(posedge clock) disable iff (reset)
      (csr.valid && csr.ready && (csr.index == CSR_BIT_TICKS))
      |=> (bit_ticks_ff == $past(csr.data[TickW-1:0])))
      else $error("bit_ticks write lost");
`endif

endmodule : inverted_serial_burst_receiver_top

`default_nettype wire
